// ===== rtl/rwlm_pkg.sv =====
// Shared types and constants for the work runtime latency monitor.
`default_nettype none
package rwlm_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_END   = 1'b1;

   typedef struct packed {
      logic        is_end;
      logic [7:0]  cpu_index;
      logic [63:0] work_handle;
      logic [63:0] function_address;
      logic [63:0] timestamp_ns;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  cpu;
      logic [63:0] handle;
      logic [63:0] start_time;
      logic [63:0] func;
   } slot_type;

   typedef struct packed {
      logic pop;
      logic open;
   } queue_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/rwlm_front.sv =====
// Input stage: accepts event beats, classifies them and queues them for the engine.
`default_nettype none
module rwlm_front
   import rwlm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_opcode,
   input  wire logic [7:0]    req_cpu_index,
   input  wire logic [63:0]   req_work_handle,
   input  wire logic [63:0]   req_function_address,
   input  wire logic [63:0]   req_timestamp_ns,
   input  wire queue_ctl_type ctl,
   output logic               q_valid,
   output item_type           q_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   new_item;

   assign req_stall = (count_ff == 2'd2) || !ctl.open;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = ctl.pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_end           = (req_opcode == OP_END);
      new_item.cpu_index        = req_cpu_index;
      new_item.work_handle      = req_work_handle;
      new_item.function_address = req_function_address;
      new_item.timestamp_ns     = req_timestamp_ns;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rwlm_engine.sv =====
// Table engine: scans the slot memory per event, updates it and forms result beats.
`default_nettype none
module rwlm_engine
   import rwlm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire item_type      q_item,
   output queue_ctl_type      ctl,
   input  wire logic [62:0]   threshold,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_out_cpu,
   output logic [63:0]        rsp_out_function_address,
   output logic [63:0]        rsp_out_start_time,
   output logic [63:0]        rsp_out_end_time,
   output logic [62:0]        rsp_out_duration,
   output logic [62:0]        rsp_out_total,
   output logic               rsp_out_count
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE} state_type;

   slot_type              mem [TABLE_ENTRIES];
   slot_type              rd_data_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   slot_type              mem_wdata;

   state_type             state_ff;
   logic [SLOT_W-1:0]     clr_addr_ff;
   item_type              item_ff;
   logic                  issuing_ff;
   logic [SLOT_W-1:0]     rd_addr_ff;
   logic                  chk_valid_ff;
   logic [SLOT_W-1:0]     chk_slot_ff;
   logic                  match_ff;
   logic [SLOT_W-1:0]     match_slot_ff;
   logic [63:0]           match_start_ff;
   logic [63:0]           match_func_ff;
   logic                  free_found_ff;
   logic [SLOT_W-1:0]     free_slot_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            cpu_ff;
   logic [63:0]           func_ff;
   logic [63:0]           start_ff;
   logic [63:0]           end_ff;
   logic [62:0]           dur_ff;

   logic [63:0]           delta;
   logic                  emit;
   logic                  out_free;
   logic                  can_go;
   logic                  hit;
   logic                  load_rsp;

   assign delta    = item_ff.timestamp_ns - match_start_ff;
   assign emit     = item_ff.is_end && match_ff && !delta[63] && (delta[62:0] > threshold);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_go   = !emit || out_free;
   assign load_rsp = (state_ff == ST_DECIDE) && can_go && emit;
   assign hit      = rd_data_ff.valid && (rd_data_ff.cpu == item_ff.cpu_index)
                     && (rd_data_ff.handle == item_ff.work_handle);

   assign ctl.open = (state_ff != ST_CLEAR);
   assign ctl.pop  = (state_ff == ST_IDLE);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_DECIDE: begin
            if (!item_ff.is_end) begin
               mem_we                = !match_ff && free_found_ff;
               mem_waddr             = free_slot_ff;
               mem_wdata.valid       = 1'b1;
               mem_wdata.cpu         = item_ff.cpu_index;
               mem_wdata.handle      = item_ff.work_handle;
               mem_wdata.start_time  = item_ff.timestamp_ns;
               mem_wdata.func        = item_ff.function_address;
            end else begin
               mem_we    = match_ff && !delta[63] && can_go;
               mem_waddr = match_slot_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issuing_ff   <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
               if (clr_addr_ff == LAST_SLOT) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff       <= q_item;
                  rd_addr_ff    <= '0;
                  issuing_ff    <= 1'b1;
                  chk_valid_ff  <= 1'b0;
                  match_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issuing_ff) begin
                  rd_addr_ff <= rd_addr_ff + SLOT_W'(1);
                  if (rd_addr_ff == LAST_SLOT) begin
                     issuing_ff <= 1'b0;
                  end
               end
               chk_valid_ff <= issuing_ff;
               chk_slot_ff  <= rd_addr_ff;
               if (chk_valid_ff) begin
                  if (hit) begin
                     match_ff       <= 1'b1;
                     match_slot_ff  <= chk_slot_ff;
                     match_start_ff <= rd_data_ff.start_time;
                     match_func_ff  <= rd_data_ff.func;
                  end
                  if (!rd_data_ff.valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= chk_slot_ff;
                  end
                  if (chk_slot_ff == LAST_SLOT) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_DECIDE: begin
               if (can_go) begin
                  state_ff <= ST_IDLE;
                  if (emit) begin
                     cpu_ff       <= item_ff.cpu_index;
                     func_ff      <= match_func_ff;
                     start_ff     <= match_start_ff;
                     end_ff       <= item_ff.timestamp_ns;
                     dur_ff       <= delta[62:0];
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_out_cpu              = cpu_ff;
   assign rsp_out_function_address = func_ff;
   assign rsp_out_start_time       = start_ff;
   assign rsp_out_end_time         = end_ff;
   assign rsp_out_duration         = dur_ff;
   assign rsp_out_total            = dur_ff;
   assign rsp_out_count            = 1'b1;

endmodule
`default_nettype wire

// ===== rtl/work_runtime_latency_monitor_unit.sv =====
// Top level of the work runtime latency monitor.
// The req_ channel carries start and end events keyed by (cpu, work handle);
// a beat is taken when req_valid is high and req_stall is low. The rsp_
// channel carries one record for each end event whose duration exceeds the
// threshold in csr_write_data, written with csr_write_enable.
// A two-beat queue sits between the input and the table engine. For every
// event the engine scans all TABLE_ENTRIES slots of its memory through one
// registered read port and takes the next event from the queue only once it
// has finished the current one; a record is loaded into the output register
// when the engine decides on its end event.
// After reset the engine clears every slot of the table and holds req_stall
// high meanwhile. A result waits in the output register while rsp_stall is
// high; the engine holds a further record until it is taken, and the input
// queue keeps taking beats until it is full.
`default_nettype none
module work_runtime_latency_monitor_unit
   import rwlm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_cpu_index,
   input  wire logic [63:0] req_work_handle,
   input  wire logic [63:0] req_function_address,
   input  wire logic [63:0] req_timestamp_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_cpu,
   output logic [63:0]      rsp_out_function_address,
   output logic [63:0]      rsp_out_start_time,
   output logic [63:0]      rsp_out_end_time,
   output logic [62:0]      rsp_out_duration,
   output logic [62:0]      rsp_out_total,
   output logic             rsp_out_count,
   input  wire logic        csr_write_enable,
   input  wire logic [62:0] csr_write_data
);

   logic [62:0]   threshold_ff;
   queue_ctl_type ctl;
   logic          q_valid;
   item_type      q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   rwlm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_cpu_index        (req_cpu_index),
      .req_work_handle      (req_work_handle),
      .req_function_address (req_function_address),
      .req_timestamp_ns     (req_timestamp_ns),
      .ctl                  (ctl),
      .q_valid              (q_valid),
      .q_item               (q_item)
   );

   rwlm_engine u_engine (
      .clock                    (clock),
      .reset                    (reset),
      .q_valid                  (q_valid),
      .q_item                   (q_item),
      .ctl                      (ctl),
      .threshold                (threshold_ff),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_out_cpu              (rsp_out_cpu),
      .rsp_out_function_address (rsp_out_function_address),
      .rsp_out_start_time       (rsp_out_start_time),
      .rsp_out_end_time         (rsp_out_end_time),
      .rsp_out_duration         (rsp_out_duration),
      .rsp_out_total            (rsp_out_total),
      .rsp_out_count            (rsp_out_count)
   );

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("Input taken while the slot table is being cleared.");

   a_duration_math: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_end_time - rsp_out_start_time) == {1'b0, rsp_out_duration})
      else $error("Reported duration does not match its timestamps.");

   a_total_equals_duration: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_total == rsp_out_duration) && rsp_out_count)
      else $error("Reported total or count is inconsistent.");

endmodule
`default_nettype wire
